[hw/rtl/bsl_pkg.sv]
// Shared types and codes for the bounded sequential list.
package bsl_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = 5;
  localparam int POS_W = 4;

  localparam logic [2:0] MODE_APPEND = 3'd0;
  localparam logic [2:0] MODE_REMOVE = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_ERASE  = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_READ   = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_LOAD = 2'd1;
  localparam logic [1:0] CELL_INS  = 2'd2;
  localparam logic [1:0] CELL_ERS  = 2'd3;

  typedef struct packed {
    logic [2:0]        mode;
    logic [POS_W-1:0]  position;
    logic signed [31:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CNT_W-1:0]   element_count;
    logic               is_empty;
    logic signed [31:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [CNT_W-1:0] tgt;
  } cell_cmd_t;

endpackage

[hw/rtl/bsl_cell.sv]
// One list cell: holds one word, loads it or takes a neighbor's word.
module bsl_cell #(
  parameter int WORD_BITS = 32,
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  bsl_pkg::cell_cmd_t          cmd,
  input  logic signed [WORD_BITS-1:0] new_word,
  input  logic signed [WORD_BITS-1:0] left_word,
  input  logic signed [WORD_BITS-1:0] right_word,
  output logic signed [WORD_BITS-1:0] word
);
  import bsl_pkg::*;

  logic signed [WORD_BITS-1:0] word_r;
  logic signed [WORD_BITS-1:0] word_nxt;
  logic                        at_tgt;
  logic                        above_tgt;

  assign at_tgt    = (int'(cmd.tgt) == IDX);
  assign above_tgt = (IDX > int'(cmd.tgt));

  always_comb begin
    unique case (cmd.op)
      CELL_HOLD: word_nxt = word_r;
      CELL_LOAD: word_nxt = at_tgt ? new_word : word_r;
      CELL_INS:  word_nxt = at_tgt ? new_word : (above_tgt ? left_word : word_r);
      CELL_ERS:  word_nxt = (at_tgt || above_tgt) ? right_word : word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

[hw/rtl/bounded_sequential_list.sv]
// Top level of the bounded sequential list: control, cell row and result register.
//
// An ordered list of signed words held in a row of DEPTH cells, one word per
// cell. Append, remove last, insert, erase, clear and read each complete in the
// cycle the item is accepted: insert and erase move every later cell by one
// position at once, each cell taking its neighbor's word. One item is accepted
// per clock; the result sits in an output register and a new item is accepted
// in the same cycle the previous result is taken. The user must write the capacity
// register through the cfg port only while the list is idle; the block does not
// enforce it; above DEPTH it counts as DEPTH. Only count, capacity and valid reset.
module bounded_sequential_list #(
  parameter int WORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  bsl_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output bsl_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bsl_pkg::CNT_W-1:0]       cfg_data
);
  import bsl_pkg::*;

  logic [CNT_W-1:0]            cap_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [CNT_W-1:0]            lim;
  logic                        out_valid_r;
  out_item_t                   out_data_r;
  logic                        accept;
  logic                        full;
  logic                        empty;
  logic [CNT_W-1:0]            pos_ext;
  logic [1:0]                  st;
  logic signed [31:0]          rd;
  logic signed [WORD_BITS-1:0] store_word;
  logic signed [WORD_BITS-1:0] sel_word;
  logic signed [WORD_BITS-1:0] cell_word [DEPTH];
  cell_cmd_t                   cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lim        = (int'(cap_r) > DEPTH) ? CNT_W'(DEPTH) : cap_r;
  assign full       = (cnt_r >= lim);
  assign empty      = (cnt_r == '0);
  assign pos_ext    = {1'b0, in_data.position};
  assign store_word = WORD_BITS'(in_data.item_value);

  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (int'(in_data.position) == i) begin
        sel_word = cell_word[i];
      end
    end
  end

  always_comb begin
    st      = ST_OK;
    cmd.op  = CELL_HOLD;
    cmd.tgt = cnt_r;
    cnt_nxt = cnt_r;
    rd      = '0;
    unique case (in_data.mode)
      MODE_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd.op  = CELL_LOAD;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      MODE_INSERT: begin
        if (pos_ext > cnt_r) begin
          st = ST_BADPOS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd.op  = CELL_INS;
          cmd.tgt = pos_ext;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      MODE_ERASE: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= cnt_r) begin
          st = ST_BADPOS;
        end else begin
          cmd.op  = CELL_ERS;
          cmd.tgt = pos_ext;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      MODE_CLEAR: begin
        cnt_nxt = '0;
      end
      MODE_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_ext >= cnt_r) begin
          st = ST_BADPOS;
        end else begin
          rd = 32'(sel_word);
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.op = CELL_HOLD;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [WORD_BITS-1:0] left_w;
    logic signed [WORD_BITS-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_word[g];
    end else begin : g_left
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_right
      assign right_w = cell_word[g+1];
    end
    bsl_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX       (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .new_word   (store_word),
      .left_word  (left_w),
      .right_word (right_w),
      .word       (cell_word[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CNT_W'(16);
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r.status        <= st;
      out_data_r.element_count <= cnt_nxt;
      out_data_r.is_empty      <= (cnt_nxt == '0);
      out_data_r.read_value    <= rd;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= DEPTH)
    else $error("entry count above store depth");

  a_err_keeps_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (st != ST_OK) |=> cnt_r == $past(cnt_r))
    else $error("count changed on an error status");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && (out_data_r.element_count == cnt_r))
    else $error("result missing or count mismatch after item");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r.is_empty == (out_data_r.element_count == '0))
    else $error("empty flag does not match count");
`endif

endmodule
